// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the spectrum top-three peak picker.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int LEVEL_W = 16;
    localparam int BIN_W   = 8;
    localparam int EDGE_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [BIN_W-1:0]          t_bin;
    typedef logic [EDGE_W-1:0]         t_edge;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_FLOOR    = 2'd0,
        CFG_AVG_LOW_EDGE  = 2'd1,
        CFG_AVG_HIGH_EDGE = 2'd2
    } t_cfg_idx;

    localparam t_level PEAK_FLOOR_RST    = 16'sd0;
    localparam t_edge  AVG_LOW_EDGE_RST  = 9'd5;
    localparam t_edge  AVG_HIGH_EDGE_RST = 9'd122;

    // Control from the bin pipeline to the peak table.
    typedef struct packed {
        logic step;       // an item is processed this cycle
        logic judge;      // the middle level of the window is a candidate
        logic frame_end;  // this item closes the frame
    } t_tab_ctrl;

endpackage

// ===== rtl/stp_peak_table.sv =====
// ----------------------------------------------------------------------------
// stp_peak_table
// Sorted peak table: a candidate takes the first entry it strictly beats and
// pushes the entries below it down by one. Reloads the floor at frame end.
// ----------------------------------------------------------------------------
module stp_peak_table #(
    parameter int PEAK_SLOTS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stp_pkg::t_tab_ctrl i_ctrl,
    input  stp_pkg::t_level    i_cand_level,
    input  stp_pkg::t_bin      i_cand_bin,
    input  stp_pkg::t_level    i_floor,
    output stp_pkg::t_level    o_next_level [PEAK_SLOTS],
    output stp_pkg::t_bin      o_next_bin [PEAK_SLOTS]
);
    import stp_pkg::*;

    t_level r_level [PEAK_SLOTS];
    t_bin   r_bin [PEAK_SLOTS];
    t_level n_level [PEAK_SLOTS];
    t_bin   n_bin [PEAK_SLOTS];

    // Only the first beaten entry takes the candidate; entries after it
    // take their upper neighbor.
    always_comb begin
        logic taken;
        taken = 1'b0;
        for (int j = 0; j < PEAK_SLOTS; j++) begin
            n_level[j] = r_level[j];
            n_bin[j]   = r_bin[j];
            if (taken) begin
                n_level[j] = r_level[(j > 0) ? j - 1 : 0];
                n_bin[j]   = r_bin[(j > 0) ? j - 1 : 0];
            end else if (i_ctrl.judge && (i_cand_level > r_level[j])) begin
                n_level[j] = i_cand_level;
                n_bin[j]   = i_cand_bin;
                taken      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PEAK_SLOTS; j++) begin
                r_level[j] <= PEAK_FLOOR_RST;
                r_bin[j]   <= '0;
            end
        end else if (i_ctrl.step) begin
            for (int j = 0; j < PEAK_SLOTS; j++) begin
                r_level[j] <= i_ctrl.frame_end ? i_floor : n_level[j];
                r_bin[j]   <= i_ctrl.frame_end ? '0 : n_bin[j];
            end
        end
    end

    assign o_next_level = n_level;
    assign o_next_bin   = n_bin;

endmodule

// ===== rtl/spectrum_top3_peak_picker.sv =====
// ----------------------------------------------------------------------------
// spectrum_top3_peak_picker
// Picks the three highest window peaks of a spectrum frame and averages the
// edge bins. One result item leaves at the end of each frame.
// ----------------------------------------------------------------------------
// From input accept to the output, the path runs through the input register and the result register.
// Throughput: one bin per cycle; the input register feeds the window, compare
// and table insert logic, which feeds the result register.
// The input side stalls only when a frame result waits at the output.
// Reset (synchronous, active low) clears the frame state and loads the
// register reset values; no clearing pass follows.
module spectrum_top3_peak_picker #(
    parameter int FRAME_BINS = 256,
    parameter int PEAK_SLOTS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [stp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  stp_pkg::t_level                     i_level_db,
    input  logic                                i_last_bin,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output stp_pkg::t_level                     o_peak_level_a,
    output stp_pkg::t_level                     o_peak_level_b,
    output stp_pkg::t_level                     o_peak_level_c,
    output stp_pkg::t_bin                       o_peak_bin_a,
    output stp_pkg::t_bin                       o_peak_bin_b,
    output stp_pkg::t_bin                       o_peak_bin_c,
    output stp_pkg::t_level                     o_average_level
);
    import stp_pkg::*;

    localparam int BIN_LIMIT_I = ((FRAME_BINS - 1) < 255) ? (FRAME_BINS - 1) : 255;
    localparam t_bin BIN_LIMIT = t_bin'(BIN_LIMIT_I);

    // Configuration registers.
    t_level r_peak_floor;
    t_edge  r_avg_low_edge;
    t_edge  r_avg_high_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_floor    <= PEAK_FLOOR_RST;
            r_avg_low_edge  <= AVG_LOW_EDGE_RST;
            r_avg_high_edge <= AVG_HIGH_EDGE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PEAK_FLOOR:    r_peak_floor    <= t_level'(i_cfg_data);
                CFG_AVG_LOW_EDGE:  r_avg_low_edge  <= i_cfg_data[EDGE_W-1:0];
                CFG_AVG_HIGH_EDGE: r_avg_high_edge <= i_cfg_data[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic   r_in_valid;
    t_level r_level;
    logic   r_last;

    // Frame state.
    t_level r_win0;
    t_level r_win1;
    t_bin   r_bin_cnt;
    t_level r_avg;

    logic   frame_end;
    logic   advance;
    logic   avg_hit;
    logic   rising;
    logic   falling;
    logic signed [LEVEL_W:0] avg_sum;
    t_level n_avg;
    t_tab_ctrl tab_ctrl;
    t_level tab_level [PEAK_SLOTS];
    t_bin   tab_bin [PEAK_SLOTS];
    t_level res_level [3];
    t_bin   res_bin [3];

    assign frame_end = r_last || (r_bin_cnt >= BIN_LIMIT);
    // A bin that closes no frame never waits on the output side.
    assign advance    = r_in_valid && (!frame_end || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_level <= i_level_db;
            r_last  <= i_last_bin;
        end
    end

    assign avg_hit = ({1'b0, r_bin_cnt} < r_avg_low_edge) ||
                     ({1'b0, r_bin_cnt} > r_avg_high_edge);
    assign avg_sum = {r_level[LEVEL_W-1], r_level} + {r_avg[LEVEL_W-1], r_avg};
    assign n_avg   = avg_hit ? t_level'(avg_sum[LEVEL_W:1]) : r_avg;

    assign rising  = (r_win1 < r_win0) && (r_win0 < r_level);
    assign falling = (r_win1 > r_win0) && (r_win0 > r_level);

    assign tab_ctrl.step      = advance;
    assign tab_ctrl.judge     = (r_bin_cnt >= t_bin'(2)) && !rising && !falling;
    assign tab_ctrl.frame_end = frame_end;

    stp_peak_table #(
        .PEAK_SLOTS (PEAK_SLOTS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tab_ctrl),
        .i_cand_level (r_win0),
        .i_cand_bin   (r_bin_cnt - t_bin'(1)),
        .i_floor      (r_peak_floor),
        .o_next_level (tab_level),
        .o_next_bin   (tab_bin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0    <= '0;
            r_win1    <= '0;
            r_bin_cnt <= t_bin'(1);
            r_avg     <= '0;
        end else if (advance) begin
            if (frame_end) begin
                r_win0    <= '0;
                r_win1    <= '0;
                r_bin_cnt <= t_bin'(1);
                r_avg     <= '0;
            end else begin
                r_win0    <= r_level;
                r_win1    <= r_win0;
                r_bin_cnt <= r_bin_cnt + t_bin'(1);
                r_avg     <= n_avg;
            end
        end
    end

    // Output fields beyond the table size show the current floor.
    for (genvar g = 0; g < 3; g++) begin : g_res
        if (g < PEAK_SLOTS) begin : g_tab
            assign res_level[g] = tab_level[g];
            assign res_bin[g]   = tab_bin[g];
        end else begin : g_floor
            assign res_level[g] = r_peak_floor;
            assign res_bin[g]   = '0;
        end
    end

    // Result register.
    logic   r_out_valid;
    t_level r_res_level [3];
    t_bin   r_res_bin [3];
    t_level r_res_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && frame_end) begin
            r_res_level <= res_level;
            r_res_bin   <= res_bin;
            r_res_avg   <= n_avg;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_peak_level_a  = r_res_level[0];
    assign o_peak_level_b  = r_res_level[1];
    assign o_peak_level_c  = r_res_level[2];
    assign o_peak_bin_a    = r_res_bin[0];
    assign o_peak_bin_b    = r_res_bin[1];
    assign o_peak_bin_c    = r_res_bin[2];
    assign o_average_level = r_res_avg;

endmodule

// ===== rtl/stp_checker.sv =====
// ----------------------------------------------------------------------------
// stp_checker
// Port-level checks for the peak picker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module stp_checker #(
    parameter int PEAK_SLOTS = 3
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input stp_pkg::t_level                o_peak_level_a,
    input stp_pkg::t_level                o_peak_level_b,
    input stp_pkg::t_level                o_peak_level_c,
    input stp_pkg::t_bin                  o_peak_bin_a,
    input stp_pkg::t_bin                  o_peak_bin_b,
    input stp_pkg::t_level                o_average_level
);
    import stp_pkg::*;

    // A stalled result item holds its first peak level, its first bin and its average.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_peak_level_a)
            && $stable(o_peak_bin_a) && $stable(o_average_level))
        else $error("result item changed while stalled");

    // With the result register empty the input side is never blocked.
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // The table stays sorted, highest level first.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((PEAK_SLOTS < 2) || (o_peak_level_a >= o_peak_level_b))
            && ((PEAK_SLOTS < 3) || (o_peak_level_b >= o_peak_level_c)))
        else $error("peak levels out of order");

    // Slots fill from the top: an empty first slot means an empty second one.
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_peak_bin_a == '0) |-> (o_peak_bin_b == '0))
        else $error("peak slot filled out of order");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind spectrum_top3_peak_picker stp_checker #(
    .PEAK_SLOTS (PEAK_SLOTS)
) u_stp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_peak_level_a  (o_peak_level_a),
    .o_peak_level_b  (o_peak_level_b),
    .o_peak_level_c  (o_peak_level_c),
    .o_peak_bin_a    (o_peak_bin_a),
    .o_peak_bin_b    (o_peak_bin_b),
    .o_average_level (o_average_level)
);

// ===== tb/stp_peak_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stp_peak_checker
// Watches the register port and both item channels of the peak picker. It
// keeps its own copy of the window, the peak table, and the edge average, and
// works out each frame result when the bins go in. Each result item that
// leaves the block is compared field by field with the oldest pending frame.
// ----------------------------------------------------------------------------
module stp_peak_checker #(
    parameter int FRAME_BINS = 256,
    parameter int PEAK_SLOTS = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [stp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  stp_pkg::t_level                i_level_db,
    input  logic                           i_last_bin,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  stp_pkg::t_level                i_peak_level_a,
    input  stp_pkg::t_level                i_peak_level_b,
    input  stp_pkg::t_level                i_peak_level_c,
    input  stp_pkg::t_bin                  i_peak_bin_a,
    input  stp_pkg::t_bin                  i_peak_bin_b,
    input  stp_pkg::t_bin                  i_peak_bin_c,
    input  stp_pkg::t_level                i_average_level,
    output int                             o_errors,
    output int                             o_pending
);
    import stp_pkg::*;

    // A frame is closed by force once the bin index reaches this value.
    localparam int BIN_LIMIT = (FRAME_BINS - 1 < 255) ? FRAME_BINS - 1 : 255;

    typedef struct packed {
        t_level lv_a;
        t_level lv_b;
        t_level lv_c;
        t_bin   bn_a;
        t_bin   bn_b;
        t_bin   bn_c;
        t_level avg;
    } t_frame_peaks;

    t_level floor_reg;
    t_edge  low_edge;
    t_edge  high_edge;

    t_level win_mid;
    t_level win_old;
    t_bin   bin_idx;
    t_level peak_lv [PEAK_SLOTS];
    t_bin   peak_bn [PEAK_SLOTS];
    t_level avg_acc;

    t_frame_peaks frame_peaks_q [$];
    int err_count = 0;
    int pending_cnt = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_cnt;

    task automatic open_frame();
        win_mid = '0;
        win_old = '0;
        bin_idx = 8'd1;
        for (int j = 0; j < PEAK_SLOTS; j++) begin
            peak_lv[j] = floor_reg;
            peak_bn[j] = '0;
        end
        avg_acc = '0;
    endtask

    // Slots beyond the table size report the floor and an empty bin.
    function automatic t_level slot_level(input int j);
        if (j < PEAK_SLOTS) return peak_lv[j];
        return floor_reg;
    endfunction

    function automatic t_bin slot_bin(input int j);
        if (j < PEAK_SLOTS) return peak_bn[j];
        return '0;
    endfunction

    task automatic update_peak_table(input t_level cur, input logic last);
        logic signed [LEVEL_W:0] level_sum;
        logic rising;
        logic falling;
        logic placed;
        t_frame_peaks res;
        if (({1'b0, bin_idx} < low_edge) || ({1'b0, bin_idx} > high_edge)) begin
            // The halving is a floor shift of the 17 bit sum.
            level_sum = {cur[LEVEL_W-1], cur} + {avg_acc[LEVEL_W-1], avg_acc};
            avg_acc = level_sum[LEVEL_W:1];
        end
        if (bin_idx >= 8'd2) begin
            rising  = (win_old < win_mid) && (win_mid < cur);
            falling = (win_old > win_mid) && (win_mid > cur);
            placed  = 1'b0;
            if (!rising && !falling) begin
                for (int j = 0; j < PEAK_SLOTS; j++) begin
                    if (!placed && win_mid > peak_lv[j]) begin
                        for (int k = PEAK_SLOTS - 1; k > j; k--) begin
                            peak_lv[k] = peak_lv[k-1];
                            peak_bn[k] = peak_bn[k-1];
                        end
                        peak_lv[j] = win_mid;
                        peak_bn[j] = bin_idx - 8'd1;
                        placed = 1'b1;
                    end
                end
            end
        end
        win_old = win_mid;
        win_mid = cur;
        if (last || (int'(bin_idx) >= BIN_LIMIT)) begin
            res.lv_a = slot_level(0);
            res.lv_b = slot_level(1);
            res.lv_c = slot_level(2);
            res.bn_a = slot_bin(0);
            res.bn_b = slot_bin(1);
            res.bn_c = slot_bin(2);
            res.avg  = avg_acc;
            frame_peaks_q.push_back(res);
            open_frame();
        end else begin
            bin_idx = bin_idx + 8'd1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_peaks want;
        if (!i_rst_n) begin
            floor_reg = PEAK_FLOOR_RST;
            low_edge  = AVG_LOW_EDGE_RST;
            high_edge = AVG_HIGH_EDGE_RST;
            open_frame();
            frame_peaks_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PEAK_FLOOR:    floor_reg = i_cfg_data;
                    CFG_AVG_LOW_EDGE:  low_edge  = i_cfg_data[EDGE_W-1:0];
                    CFG_AVG_HIGH_EDGE: high_edge = i_cfg_data[EDGE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_peaks_q.size() == 0) begin
                    $error("result item arrived with no frame pending");
                    err_count++;
                end else begin
                    want = frame_peaks_q.pop_front();
                    check_field("peak_level_a", int'(want.lv_a), int'(i_peak_level_a));
                    check_field("peak_level_b", int'(want.lv_b), int'(i_peak_level_b));
                    check_field("peak_level_c", int'(want.lv_c), int'(i_peak_level_c));
                    check_field("peak_bin_a", int'(want.bn_a), int'(i_peak_bin_a));
                    check_field("peak_bin_b", int'(want.bn_b), int'(i_peak_bin_b));
                    check_field("peak_bin_c", int'(want.bn_c), int'(i_peak_bin_c));
                    check_field("average_level", int'(want.avg), int'(i_average_level));
                end
            end
            if (i_in_valid && i_in_ready) begin
                update_peak_table(i_level_db, i_last_bin);
            end
        end
        pending_cnt = frame_peaks_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives spectrum frames into the peak picker through bursty input traffic
// and a stalling receiver, across several floor and edge settings, and
// reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module testbench;
    import stp_pkg::*;

    localparam int FRAME_BINS     = 256;
    localparam int PEAK_SLOTS     = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int OVERLONG_BINS  = 280;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    t_level                i_level_db = '0;
    logic                  i_last_bin = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_level                o_peak_level_a;
    t_level                o_peak_level_b;
    t_level                o_peak_level_c;
    t_bin                  o_peak_bin_a;
    t_bin                  o_peak_bin_b;
    t_bin                  o_peak_bin_c;
    t_level                o_average_level;

    int       frame_errors;
    int       frames_pending;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       rx_left = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    logic     hold_out = 1'b0;

    always #1 i_clk = ~i_clk;

    spectrum_top3_peak_picker #(
        .FRAME_BINS(FRAME_BINS),
        .PEAK_SLOTS(PEAK_SLOTS)
    ) i_dut (.*);

    stp_peak_checker #(
        .FRAME_BINS(FRAME_BINS),
        .PEAK_SLOTS(PEAK_SLOTS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_level_db     (i_level_db),
        .i_last_bin     (i_last_bin),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_peak_level_a (o_peak_level_a),
        .i_peak_level_b (o_peak_level_b),
        .i_peak_level_c (o_peak_level_c),
        .i_peak_bin_a   (o_peak_bin_a),
        .i_peak_bin_b   (o_peak_bin_b),
        .i_peak_bin_c   (o_peak_bin_c),
        .i_average_level(o_average_level),
        .o_errors       (frame_errors),
        .o_pending      (frames_pending)
    );

    // The run is cut short when neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // The receiver switches between stall patterns, and on request holds off
    // for a long stretch so that the block backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(3, 0));
                    rx_left = $urandom_range(96, 16);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    RX_ALWAYS:   i_out_ready <= 1'b1;
                    RX_COIN:     i_out_ready <= 1'($urandom_range(1, 0));
                    RX_SPARSE:   i_out_ready <= ($urandom_range(3, 0) == 0);
                    RX_PERIODIC: i_out_ready <= rx_tick[2];
                    default:     i_out_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic idle_input(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Items go out in bursts; a third of the bursts follow with no gap.
    task automatic send_bin(input t_level level, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(2, 0) != 0) idle_input($urandom_range(10, 1));
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_level_db <= level;
        i_last_bin <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Edge writes carry random upper bits, which the block must drop.
    task automatic configure(input t_level floor_lv, input t_edge low, input t_edge high);
        logic [CFG_DATA_W-1:0] data;
        write_reg(CFG_PEAK_FLOOR, floor_lv);
        data = CFG_DATA_W'($urandom);
        data[EDGE_W-1:0] = low;
        write_reg(CFG_AVG_LOW_EDGE, data);
        data = CFG_DATA_W'($urandom);
        data[EDGE_W-1:0] = high;
        write_reg(CFG_AVG_HIGH_EDGE, data);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Narrow levels make flat spots common; extremes stress the compares.
    function automatic t_level random_level();
        t_level lv;
        case ($urandom_range(3, 0))
            2: lv = t_level'($urandom_range(8, 0)) - 16'sd4;
            3: lv = $urandom_range(1, 0) ? t_level'(16'sh7FFF - $urandom_range(1, 0))
                                         : t_level'(16'sh8000 + $urandom_range(1, 0));
            default: lv = t_level'($urandom);
        endcase
        return lv;
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_bin(random_level(), i == len - 1);
        end
    endtask

    task automatic send_frames(input int count, input int max_len);
        int r;
        repeat (count) begin
            r = $urandom_range(9, 0);
            if (r == 0) send_frame(1);
            else if (r < 4) send_frame($urandom_range(6, 2));
            else send_frame($urandom_range(max_len, 7));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings. A one-bin frame, a two-bin frame, then rising,
        // falling, flat and valley shapes, ending on a level that is never
        // judged because it is the final bin.
        send_bin(16'sh7FFF, 1'b1);
        send_bin(16'sh8000, 1'b0);
        send_bin(16'sd12345, 1'b1);
        send_bin(16'sh8000, 1'b0);
        send_bin(16'sh7FFF, 1'b0);
        send_bin(16'sh8000, 1'b0);
        send_bin(16'sh7FFF, 1'b0);
        send_bin(16'sd100, 1'b0);
        send_bin(16'sd100, 1'b0);
        send_bin(16'sd100, 1'b0);
        send_bin(-16'sd300, 1'b0);
        send_bin(-16'sd400, 1'b0);
        send_bin(-16'sd200, 1'b0);
        send_bin(16'sd500, 1'b0);
        send_bin(16'sd400, 1'b0);
        send_bin(16'sd900, 1'b1);
        drain();

        configure(16'sh8000, 9'd0, 9'd511);
        send_frames(5, 20);
        drain();
        configure(16'sh7FFF, 9'd511, 9'd0);
        send_frames(5, 20);
        drain();
        configure(16'sd0, 9'd256, 9'd256);
        send_frames(5, 20);
        drain();
        repeat (2) begin
            configure(t_level'($urandom), t_edge'($urandom_range(511, 0)),
                      t_edge'($urandom_range(511, 0)));
            send_frames(5, 20);
            drain();
        end

        // Short frames while the receiver holds off fill the block up.
        configure(t_level'($urandom_range(200, 0)) - 16'sd100, 9'd5, 9'd122);
        hold_out = 1'b1;
        send_frames(15, 8);
        drain();

        // Longer than the bin limit: the block closes the frame at its limit and
        // the remaining bins form the next frame, closed by the final marker.
        configure(-16'sd256, AVG_LOW_EDGE_RST, AVG_HIGH_EDGE_RST);
        for (int i = 0; i < OVERLONG_BINS; i++) begin
            send_bin(random_level(), i == OVERLONG_BINS - 1);
        end
        send_frames(5, 20);
        drain();
        repeat (8) @(posedge i_clk);

        if (frames_pending != 0) $error("%0d frame results never arrived", frames_pending);
        if (frame_errors == 0 && frames_pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/stp_pkg.sv
rtl/stp_peak_table.sv
rtl/spectrum_top3_peak_picker.sv
rtl/stp_checker.sv
tb/stp_peak_checker.sv
tb/testbench.sv
